>>> rtl/cds420_pkg.sv
// ----------------------------------------------------------------------------
// cds420_pkg: shared types and constants of the 4:2:0 chroma downsampler
// Field widths, register indexes, reset values and the position flag bundle.
// ----------------------------------------------------------------------------
package cds420_pkg;

  localparam int PIX_BITS       = 8;
  localparam int PAIR_BITS      = 9;
  localparam int QUAD_BITS      = 10;
  localparam int LINE_WORD_BITS = 2 * PAIR_BITS;
  localparam int IMG_W_BITS     = 12;
  localparam int IMG_H_BITS     = 13;
  localparam int CFG_DATA_BITS  = 13;
  localparam int IMG_W_RESET    = 352;
  localparam int IMG_H_RESET    = 288;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic odd_col;
    logic odd_row;
    logic in_pair;
    logic in_rows;
  } pos_flags_t;

endpackage

>>> rtl/cds420_if.sv
// ----------------------------------------------------------------------------
// cds420_in_if / cds420_out_if: pixel stream channels
// Valid/ready channels that carry a 4:4:4 pixel in and a 4:2:0 result out.
// ----------------------------------------------------------------------------
interface cds420_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma_in;
  logic [7:0] cb_in;
  logic [7:0] cr_in;

  modport source (output valid, output luma_in, output cb_in, output cr_in, input ready);
  modport sink (input valid, input luma_in, input cb_in, input cr_in, output ready);
endinterface

interface cds420_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma_out;
  logic       chroma_valid;
  logic [7:0] cb_avg;
  logic [7:0] cr_avg;

  modport source (output valid, output luma_out, output chroma_valid, output cb_avg,
                  output cr_avg, input ready);
  modport sink (input valid, input luma_out, input chroma_valid, input cb_avg,
                input cr_avg, output ready);
endinterface

>>> rtl/cds420_line_ram.sv
// ----------------------------------------------------------------------------
// cds420_line_ram: line buffer of pair sums
// Simple dual-port synchronous RAM with one write and one registered read port.
// ----------------------------------------------------------------------------
module cds420_line_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [AW-1:0]                        waddr,
  input  logic [cds420_pkg::LINE_WORD_BITS-1:0] wdata,
  input  logic                                 re,
  input  logic [AW-1:0]                        raddr,
  output logic [cds420_pkg::LINE_WORD_BITS-1:0] rdata
);
  import cds420_pkg::*;

  logic [LINE_WORD_BITS-1:0] mem [DEPTH];
  logic [LINE_WORD_BITS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/cds420_frame_pos.sv
// ----------------------------------------------------------------------------
// cds420_frame_pos: frame geometry registers and position counters
// Holds the clamped width and height and tracks column and row of each pixel.
// ----------------------------------------------------------------------------
module cds420_frame_pos #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096,
  parameter int AW         = 10
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  cds420_pkg::cfg_reg_e                cfg_addr,
  input  logic [cds420_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
  input  logic                                step,
  output cds420_pkg::pos_flags_t              flags,
  output logic [AW-1:0]                       slot
);
  import cds420_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WW0 = $clog2(MAX_WIDTH + 1);
  localparam int HW0 = $clog2(MAX_HEIGHT + 1);
  localparam int WW  = (WW0 > IMG_W_BITS) ? WW0 : IMG_W_BITS;
  localparam int HW  = (HW0 > IMG_H_BITS) ? HW0 : IMG_H_BITS;
  localparam int W_RESET_EFF = (IMG_W_RESET > MAX_WIDTH) ? MAX_WIDTH : IMG_W_RESET;
  localparam int H_RESET_EFF = (IMG_H_RESET > MAX_HEIGHT) ? MAX_HEIGHT : IMG_H_RESET;

  logic [WW-1:0] eff_w_r, eff_w_nxt, w_req;
  logic [HW-1:0] eff_h_r, eff_h_nxt, h_req;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [WW-1:0] col_ext;
  logic [HW-1:0] row_ext;
  logic          col_last, row_last;

  assign w_req = WW'(cfg_wdata[IMG_W_BITS-1:0]);
  assign h_req = HW'(cfg_wdata[IMG_H_BITS-1:0]);

  always_comb begin
    eff_w_nxt = eff_w_r;
    eff_h_nxt = eff_h_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_IMAGE_WIDTH: begin
          eff_w_nxt = (w_req > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : w_req;
        end
        REG_IMAGE_HEIGHT: begin
          eff_h_nxt = (h_req > HW'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : h_req;
        end
        default: begin
        end
      endcase
    end
  end

  assign col_ext  = WW'(col_r);
  assign row_ext  = HW'(row_r);
  assign col_last = (col_ext + WW'(1)) >= eff_w_r;
  assign row_last = (row_ext + HW'(1)) >= eff_h_r;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (step) begin
      if (col_last) begin
        col_nxt = '0;
        row_nxt = row_last ? '0 : row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_w_r <= WW'(W_RESET_EFF);
      eff_h_r <= HW'(H_RESET_EFF);
      col_r   <= '0;
      row_r   <= '0;
    end else begin
      eff_w_r <= eff_w_nxt;
      eff_h_r <= eff_h_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
    end
  end

  assign flags.odd_col = col_r[0];
  assign flags.odd_row = row_r[0];
  assign flags.in_pair = (col_ext | WW'(1)) < eff_w_r;
  assign flags.in_rows = (row_ext | HW'(1)) < eff_h_r;
  assign slot          = AW'(col_r >> 1);

endmodule

>>> rtl/chroma_downsample_420.sv
// ----------------------------------------------------------------------------
// chroma_downsample_420: 4:4:4 to 4:2:0 chroma subsampling by 2x2 average
// Luma passes through; U and V of each 2x2 block are averaged via a line
// buffer of horizontal pair sums written on even rows and read on odd rows.
// The s1 stage and the output register lie between a pixel and its result.
// Throughput: one pixel per cycle when not stalled; single line buffer access.
// Reset: synchronous rst_n clears counters, held samples and valid bits and
// loads the default frame size; the line buffer is not cleared.
// ----------------------------------------------------------------------------
module chroma_downsample_420 #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  cds420_pkg::cfg_reg_e                cfg_addr,
  input  logic [cds420_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
  cds420_in_if.sink                           in_pix,
  cds420_out_if.source                        out_pix
);
  import cds420_pkg::*;

  localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

  pos_flags_t                flags;
  logic [AW-1:0]             slot;
  logic                      adv, acc;
  logic [PIX_BITS-1:0]       held_cb_r, held_cr_r;
  logic [PAIR_BITS-1:0]      su, sv;
  logic                      mem_we, mem_re;
  logic [LINE_WORD_BITS-1:0] mem_rdata;

  logic                      s1_valid_r;
  logic                      s1_rd_r;
  logic [PIX_BITS-1:0]       s1_luma_r;
  logic [PAIR_BITS-1:0]      s1_su_r, s1_sv_r;

  logic [QUAD_BITS-1:0]      quad_u, quad_v;
  logic [PIX_BITS-1:0]       cb_nxt, cr_nxt;

  logic                      out_valid_r;
  logic [PIX_BITS-1:0]       out_luma_r, out_cb_r, out_cr_r;
  logic                      out_cvalid_r;

  assign adv          = !out_valid_r || out_pix.ready;
  assign in_pix.ready = adv;
  assign acc          = in_pix.valid && adv;

  cds420_frame_pos #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .AW         (AW)
  ) u_pos (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .step      (acc),
    .flags     (flags),
    .slot      (slot)
  );

  assign su = PAIR_BITS'(held_cb_r) + PAIR_BITS'(in_pix.cb_in);
  assign sv = PAIR_BITS'(held_cr_r) + PAIR_BITS'(in_pix.cr_in);

  assign mem_we = acc && flags.odd_col && flags.in_pair && !flags.odd_row;
  assign mem_re = acc && flags.odd_col && flags.in_pair && flags.odd_row && flags.in_rows;

  cds420_line_ram #(
    .DEPTH (LINE_DEPTH),
    .AW    (AW)
  ) u_line (
    .clk   (clk),
    .we    (mem_we),
    .waddr (slot),
    .wdata ({sv, su}),
    .re    (mem_re),
    .raddr (slot),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_cb_r <= '0;
      held_cr_r <= '0;
    end else if (acc && !flags.odd_col) begin
      held_cb_r <= in_pix.cb_in;
      held_cr_r <= in_pix.cr_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_rd_r    <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= acc;
      s1_rd_r    <= mem_re;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_luma_r <= in_pix.luma_in;
      s1_su_r   <= su;
      s1_sv_r   <= sv;
    end
  end

  assign quad_u = QUAD_BITS'(mem_rdata[PAIR_BITS-1:0]) + QUAD_BITS'(s1_su_r);
  assign quad_v = QUAD_BITS'(mem_rdata[LINE_WORD_BITS-1:PAIR_BITS]) + QUAD_BITS'(s1_sv_r);
  assign cb_nxt = s1_rd_r ? quad_u[QUAD_BITS-1:2] : '0;
  assign cr_nxt = s1_rd_r ? quad_v[QUAD_BITS-1:2] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      out_luma_r   <= s1_luma_r;
      out_cvalid_r <= s1_rd_r;
      out_cb_r     <= cb_nxt;
      out_cr_r     <= cr_nxt;
    end
  end

  assign out_pix.valid        = out_valid_r;
  assign out_pix.luma_out     = out_luma_r;
  assign out_pix.chroma_valid = out_cvalid_r;
  assign out_pix.cb_avg       = out_cb_r;
  assign out_pix.cr_avg       = out_cr_r;

  a_no_rw_same_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("line buffer read and write in the same cycle");

  a_read_tracked: assert property (@(posedge clk) disable iff (!rst_n)
    mem_re |=> (s1_rd_r && s1_valid_r))
    else $error("line buffer read lost its pipeline slot");

  a_chroma_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pix.valid && !out_pix.chroma_valid) |-> (out_pix.cb_avg == '0 && out_pix.cr_avg == '0))
    else $error("chroma fields not zero without a completed block");

  a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (!adv && s1_rd_r) |=> (s1_rd_r && $stable(mem_rdata)))
    else $error("stalled read data changed");

endmodule

>>> test/tb_chroma_downsample_420.sv
// ----------------------------------------------------------------------------
// tb_chroma_downsample_420: self-checking bench of the 4:2:0 chroma downsampler
// A short table of directed pixels (extreme samples, truncation, a frame size
// change inside a frame, odd and degenerate sizes) is followed by random
// frames of random size, with random gaps on both channels. Every result
// transfer is checked against a typed expected value or a cycle-free model.
// ----------------------------------------------------------------------------
module tb_chroma_downsample_420;
  timeunit 1ns;
  timeprecision 1ps;

  import cds420_pkg::*;

  localparam int MAX_W      = 2048;
  localparam int MAX_H      = 4096;
  localparam int LINE_SLOTS = (MAX_W + 1) / 2;
  localparam int RANDOM_PIX = 600;
  localparam int QUIET_FROM = 480;

  typedef struct packed {
    logic [PIX_BITS-1:0] luma;
    logic [PIX_BITS-1:0] cb;
    logic [PIX_BITS-1:0] cr;
  } pixel_t;

  typedef struct packed {
    logic [PIX_BITS-1:0] luma;
    logic                chroma_valid;
    logic [PIX_BITS-1:0] cb_avg;
    logic [PIX_BITS-1:0] cr_avg;
  } chroma_result_t;

  typedef enum logic [1:0] {
    DIR_PIXEL,
    DIR_WIDTH,
    DIR_HEIGHT
  } dir_kind_e;

  typedef struct packed {
    dir_kind_e              kind;
    logic [CFG_DATA_BITS-1:0] value;
    pixel_t                 pix;
    logic                   typed;
    chroma_result_t         want;
  } dir_row_t;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  cfg_reg_e                 cfg_addr;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;

  cds420_in_if  in_ch ();
  cds420_out_if out_ch ();

  chroma_downsample_420 #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_pix    (in_ch),
    .out_pix   (out_ch)
  );

  // Model state.
  logic [IMG_W_BITS-1:0]     frame_w = IMG_W_BITS'(IMG_W_RESET);
  logic [IMG_H_BITS-1:0]     frame_h = IMG_H_BITS'(IMG_H_RESET);
  logic [10:0]               col_pos = '0;
  logic [11:0]               row_pos = '0;
  logic [PIX_BITS-1:0]       held_cb = '0;
  logic [PIX_BITS-1:0]       held_cr = '0;
  logic [LINE_WORD_BITS-1:0] pair_sums [LINE_SLOTS];

  chroma_result_t subsampled_q [$];
  dir_row_t       dir_rows [$];
  int             error_count  = 0;
  int             result_count = 0;
  bit             src_idle_on  = 1'b1;
  bit             sink_idle_on = 1'b1;

  always #10 clk = ~clk;

  function automatic chroma_result_t downsample_pixel(pixel_t p);
    int                    eff_w;
    int                    eff_h;
    int                    slot;
    logic                  in_pair;
    logic                  in_rows;
    logic [PAIR_BITS-1:0]  sum_cb;
    logic [PAIR_BITS-1:0]  sum_cr;
    logic [QUAD_BITS-1:0]  quad_cb;
    logic [QUAD_BITS-1:0]  quad_cr;
    chroma_result_t        r;
    eff_w   = (int'(frame_w) > MAX_W) ? MAX_W : int'(frame_w);
    eff_h   = (int'(frame_h) > MAX_H) ? MAX_H : int'(frame_h);
    slot    = int'(col_pos) >> 1;
    in_pair = ((int'(col_pos) | 1) < eff_w) && (slot < LINE_SLOTS);
    in_rows = ((int'(row_pos) | 1) < eff_h);
    r.luma         = p.luma;
    r.chroma_valid = 1'b0;
    r.cb_avg       = '0;
    r.cr_avg       = '0;
    if (!col_pos[0]) begin
      held_cb = p.cb;
      held_cr = p.cr;
    end else if (in_pair) begin
      sum_cb = held_cb + p.cb;
      sum_cr = held_cr + p.cr;
      if (!row_pos[0]) begin
        pair_sums[slot] = {sum_cr, sum_cb};
      end else if (in_rows) begin
        quad_cb = pair_sums[slot][PAIR_BITS-1:0] + sum_cb;
        quad_cr = pair_sums[slot][LINE_WORD_BITS-1:PAIR_BITS] + sum_cr;
        r.chroma_valid = 1'b1;
        r.cb_avg       = quad_cb[QUAD_BITS-1:2];
        r.cr_avg       = quad_cr[QUAD_BITS-1:2];
      end
    end
    if (int'(col_pos) + 1 >= eff_w) begin
      col_pos = '0;
      if (int'(row_pos) + 1 >= eff_h) begin
        row_pos = '0;
      end else begin
        row_pos = row_pos + 1'b1;
      end
    end else begin
      col_pos = col_pos + 1'b1;
    end
    return r;
  endfunction

  function automatic logic [PIX_BITS-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return PIX_BITS'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic dir_row_t pix_row(logic [7:0] y, logic [7:0] u, logic [7:0] v);
    dir_row_t d;
    d.kind  = DIR_PIXEL;
    d.value = '0;
    d.pix   = '{luma: y, cb: u, cr: v};
    d.typed = 1'b0;
    d.want  = '0;
    return d;
  endfunction

  function automatic dir_row_t typed_row(logic [7:0] y, logic [7:0] u, logic [7:0] v,
                                         logic cv, logic [7:0] cb, logic [7:0] cr);
    dir_row_t d;
    d       = pix_row(y, u, v);
    d.typed = 1'b1;
    d.want  = '{luma: y, chroma_valid: cv, cb_avg: cb, cr_avg: cr};
    return d;
  endfunction

  function automatic dir_row_t cfg_row(dir_kind_e kind, int value);
    dir_row_t d;
    d       = pix_row('0, '0, '0);
    d.kind  = kind;
    d.value = CFG_DATA_BITS'(value);
    return d;
  endfunction

  task automatic send_pixel(pixel_t p, logic typed, chroma_result_t want);
    int             gap;
    chroma_result_t predicted;
    gap = (src_idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   = 1'b1;
    in_ch.luma_in = p.luma;
    in_ch.cb_in   = p.cb;
    in_ch.cr_in   = p.cr;
    do @(posedge clk); while (!in_ch.ready);
    predicted = downsample_pixel(p);
    subsampled_q.push_back(typed ? want : predicted);
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (subsampled_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_e addr, logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_addr  = addr;
    cfg_wdata = data;
    @(posedge clk);
    if (addr == REG_IMAGE_WIDTH) begin
      frame_w = data[IMG_W_BITS-1:0];
    end else begin
      frame_h = data[IMG_H_BITS-1:0];
    end
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  always @(posedge clk) begin
    chroma_result_t got;
    chroma_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{luma: out_ch.luma_out, chroma_valid: out_ch.chroma_valid,
              cb_avg: out_ch.cb_avg, cr_avg: out_ch.cr_avg};
      if (subsampled_q.size() == 0) begin
        error_count++;
        if (error_count <= 10) begin
          $display("result %0d: no result was due, got Y=%02h cv=%0d U=%02h V=%02h",
                   result_count, got.luma, got.chroma_valid, got.cb_avg, got.cr_avg);
        end
      end else begin
        want = subsampled_q.pop_front();
        if (got !== want) begin
          error_count++;
          if (error_count <= 10) begin
            $display("result %0d: expected Y=%02h cv=%0d U=%02h V=%02h, got Y=%02h cv=%0d U=%02h V=%02h",
                     result_count, want.luma, want.chroma_valid, want.cb_avg,
                     want.cr_avg, got.luma, got.chroma_valid, got.cb_avg, got.cr_avg);
          end
        end
      end
      result_count++;
    end
  end

  initial begin : result_sink
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
        out_ch.ready = 1'b0;
        stall_left   = $urandom_range(0, 3);
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  initial begin : watchdog
    #10_000_000;
    $display("chroma_downsample_420: mismatch");
    $finish;
  end

  initial begin : stimulus
    int                       random_count;
    int                       phase_idx;
    int                       target;
    int                       sent;
    int                       guard;
    logic [IMG_W_BITS-1:0]    w;
    logic [IMG_H_BITS-1:0]    h;
    pixel_t                   p;
    clk           = 1'b0;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_addr      = REG_IMAGE_WIDTH;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.luma_in = '0;
    in_ch.cb_in   = '0;
    in_ch.cr_in   = '0;

    // Default frame size, then a width change that leaves the column counter past it.
    dir_rows.push_back(typed_row(8'h00, 8'hFF, 8'h00, 1'b0, 8'h00, 8'h00));
    dir_rows.push_back(typed_row(8'hFF, 8'h00, 8'hFF, 1'b0, 8'h00, 8'h00));
    dir_rows.push_back(cfg_row(DIR_WIDTH, 2));
    dir_rows.push_back(typed_row(8'h5A, 8'h12, 8'h34, 1'b0, 8'h00, 8'h00));
    dir_rows.push_back(typed_row(8'h01, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00));
    dir_rows.push_back(typed_row(8'h02, 8'h01, 8'h03, 1'b1, 8'h40, 8'h40));
    dir_rows.push_back(cfg_row(DIR_HEIGHT, 2));
    dir_rows.push_back(pix_row(8'h10, 8'h55, 8'hAA));
    dir_rows.push_back(pix_row(8'h20, 8'hAA, 8'h55));
    // Extreme chroma and truncation on 2x2 frames.
    dir_rows.push_back(typed_row(8'hFF, 8'hFF, 8'h00, 1'b0, 8'h00, 8'h00));
    dir_rows.push_back(typed_row(8'h00, 8'hFF, 8'h00, 1'b0, 8'h00, 8'h00));
    dir_rows.push_back(typed_row(8'hFF, 8'hFF, 8'h00, 1'b0, 8'h00, 8'h00));
    dir_rows.push_back(typed_row(8'h00, 8'hFF, 8'h00, 1'b1, 8'hFF, 8'h00));
    dir_rows.push_back(pix_row(8'h80, 8'h00, 8'hFF));
    dir_rows.push_back(pix_row(8'h7F, 8'h00, 8'hFF));
    dir_rows.push_back(pix_row(8'h01, 8'h00, 8'hFF));
    dir_rows.push_back(typed_row(8'hFE, 8'h00, 8'hFF, 1'b1, 8'h00, 8'hFF));
    dir_rows.push_back(pix_row(8'h33, 8'hFF, 8'h01));
    dir_rows.push_back(pix_row(8'h44, 8'hFF, 8'h01));
    dir_rows.push_back(pix_row(8'h55, 8'hFF, 8'h01));
    dir_rows.push_back(typed_row(8'h66, 8'hFE, 8'h00, 1'b1, 8'hFE, 8'h00));
    // A width below two never completes a chroma block.
    dir_rows.push_back(cfg_row(DIR_WIDTH, 1));
    dir_rows.push_back(cfg_row(DIR_HEIGHT, 3));
    dir_rows.push_back(typed_row(8'h11, 8'hFF, 8'hFF, 1'b0, 8'h00, 8'h00));
    dir_rows.push_back(typed_row(8'h22, 8'hFF, 8'hFF, 1'b0, 8'h00, 8'h00));
    dir_rows.push_back(typed_row(8'h33, 8'hFF, 8'hFF, 1'b0, 8'h00, 8'h00));
    // An odd width leaves the last column out of chroma.
    dir_rows.push_back(cfg_row(DIR_WIDTH, 3));
    dir_rows.push_back(cfg_row(DIR_HEIGHT, 2));
    dir_rows.push_back(pix_row(8'hA0, 8'h10, 8'hF0));
    dir_rows.push_back(pix_row(8'hA1, 8'h20, 8'hE0));
    dir_rows.push_back(pix_row(8'hA2, 8'hFF, 8'hFF));
    dir_rows.push_back(pix_row(8'hA3, 8'h30, 8'hD0));
    dir_rows.push_back(pix_row(8'hA4, 8'h40, 8'hC0));
    dir_rows.push_back(typed_row(8'hA5, 8'hFF, 8'hFF, 1'b0, 8'h00, 8'h00));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        DIR_PIXEL: begin
          send_pixel(dir_rows[i].pix, dir_rows[i].typed, dir_rows[i].want);
        end
        DIR_WIDTH: begin
          wait_for_results();
          write_reg(REG_IMAGE_WIDTH, dir_rows[i].value);
        end
        default: begin
          wait_for_results();
          write_reg(REG_IMAGE_HEIGHT, dir_rows[i].value);
        end
      endcase
    end

    // Random frames. Each phase ends at the start of an even row, so that no
    // new frame size can make an odd row read a line buffer entry never written.
    random_count = 0;
    phase_idx    = 0;
    while (random_count < RANDOM_PIX) begin
      target    = $urandom_range(8, 60);
      case (phase_idx)
        1: begin
          w = '0;
          h = '0;
        end
        2: begin
          w = 12'd2;
          h = '1;
        end
        3: begin
          w      = 12'd160;
          h      = 13'd2;
          target = 320;
        end
        default: begin
          case ($urandom_range(0, 9))
            0: begin
              w = IMG_W_BITS'($urandom_range(0, 1));
              h = IMG_H_BITS'($urandom_range(2, 9));
            end
            1: begin
              w = IMG_W_BITS'($urandom_range(2, 12));
              h = IMG_H_BITS'($urandom_range(0, 1));
            end
            2: begin
              w = IMG_W_BITS'($urandom_range(13, 64));
              h = IMG_H_BITS'($urandom_range(2, 4));
            end
            default: begin
              w = IMG_W_BITS'($urandom_range(2, 12));
              h = IMG_H_BITS'($urandom_range(2, 8));
            end
          endcase
        end
      endcase
      wait_for_results();
      write_reg(REG_IMAGE_WIDTH, {1'($urandom_range(0, 1)), w});
      write_reg(REG_IMAGE_HEIGHT, h);
      if (random_count >= QUIET_FROM) begin
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
      end else begin
        src_idle_on  = ($urandom_range(0, 3) != 0);
        sink_idle_on = ($urandom_range(0, 3) != 0);
      end
      sent = 0;
      while (sent < target || col_pos != '0 || row_pos[0]) begin
        p.luma = rand_sample();
        p.cb   = rand_sample();
        p.cr   = rand_sample();
        send_pixel(p, 1'b0, '0);
        sent++;
      end
      random_count += sent;
      phase_idx++;
    end

    @(negedge clk);
    in_ch.valid = 1'b0;
    guard = 0;
    while (subsampled_q.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (error_count == 0 && subsampled_q.size() == 0) begin
      $display("chroma_downsample_420: match");
    end else begin
      $display("chroma_downsample_420: mismatch");
    end
    $finish;
  end

endmodule
